>>> hdl/keyword_perfect_hash_matcher_assert.svh
// ----------------------------------------------------------------------------
// Keyword perfect hash matcher assertion macros
// Concurrent assertion helpers used by the matcher's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_PERFECT_HASH_MATCHER_ASSERT_SVH
`define KEYWORD_PERFECT_HASH_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS

`define KHM_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("keyword matcher check failed");

`define KHM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("keyword matcher check failed");

`else

`define KHM_ASSERT_SAME(label, clk, rstn, ante, cons)

`define KHM_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> hdl/khm_pkg.sv
// ----------------------------------------------------------------------------
// Keyword perfect hash matcher package
// Item types, keyword codes, byte weights and the slot table of the hash.
// ----------------------------------------------------------------------------
package khm_pkg;

    localparam int unsigned WORD_BYTES_W = 64;
    localparam int unsigned WORD_LEN_W   = 8;
    localparam int unsigned CODE_W       = 5;
    localparam int unsigned HASH_W       = 7;
    localparam int unsigned SLOT_W       = 5;
    localparam int unsigned SLOT_LEN_W   = 4;

    localparam logic [WORD_LEN_W-1:0] MIN_CHARS   = 8'd2;
    localparam logic [HASH_W-1:0]     HASH_LIMIT  = 7'd29;
    localparam logic [6:0]            PLAIN_WEIGHT = 7'd30;

    localparam logic [CODE_W-1:0] KW_AND      = 5'd0;
    localparam logic [CODE_W-1:0] KW_BREAK    = 5'd1;
    localparam logic [CODE_W-1:0] KW_DO       = 5'd2;
    localparam logic [CODE_W-1:0] KW_ELSE     = 5'd3;
    localparam logic [CODE_W-1:0] KW_ELSEIF   = 5'd4;
    localparam logic [CODE_W-1:0] KW_END      = 5'd5;
    localparam logic [CODE_W-1:0] KW_FALSE    = 5'd6;
    localparam logic [CODE_W-1:0] KW_FOR      = 5'd7;
    localparam logic [CODE_W-1:0] KW_FUNCTION = 5'd8;
    localparam logic [CODE_W-1:0] KW_GOTO     = 5'd9;
    localparam logic [CODE_W-1:0] KW_IF       = 5'd10;
    localparam logic [CODE_W-1:0] KW_IN       = 5'd11;
    localparam logic [CODE_W-1:0] KW_LOCAL    = 5'd12;
    localparam logic [CODE_W-1:0] KW_NIL      = 5'd13;
    localparam logic [CODE_W-1:0] KW_NOT      = 5'd14;
    localparam logic [CODE_W-1:0] KW_OR       = 5'd15;
    localparam logic [CODE_W-1:0] KW_REPEAT   = 5'd16;
    localparam logic [CODE_W-1:0] KW_RETURN   = 5'd17;
    localparam logic [CODE_W-1:0] KW_THEN     = 5'd18;
    localparam logic [CODE_W-1:0] KW_TRUE     = 5'd19;
    localparam logic [CODE_W-1:0] KW_UNTIL    = 5'd20;
    localparam logic [CODE_W-1:0] KW_WHILE    = 5'd21;
    localparam logic [CODE_W-1:0] NO_KEYWORD  = 5'd22;

    typedef struct packed {
        logic [WORD_BYTES_W-1:0] word_bytes;
        logic [WORD_LEN_W-1:0]   word_length;
    } khm_in_t;

    typedef struct packed {
        logic [CODE_W-1:0] token_code;
        logic              is_keyword;
    } khm_out_t;

    typedef struct packed {
        logic [SLOT_LEN_W-1:0]   length;
        logic [CODE_W-1:0]       code;
        logic [WORD_BYTES_W-1:0] text;
    } khm_slot_t;

    function automatic logic [6:0] byte_weight(input logic [7:0] b);
        logic [6:0] w;
        case (b)
            8'h61:   w = 7'd10;
            8'h62:   w = 7'd10;
            8'h64:   w = 7'd15;
            8'h65:   w = 7'd5;
            8'h66:   w = 7'd5;
            8'h67:   w = 7'd15;
            8'h69:   w = 7'd0;
            8'h6B:   w = 7'd10;
            8'h6C:   w = 7'd0;
            8'h6E:   w = 7'd0;
            8'h6F:   w = 7'd10;
            8'h72:   w = 7'd0;
            8'h74:   w = 7'd15;
            8'h75:   w = 7'd15;
            8'h77:   w = 7'd0;
            default: w = PLAIN_WEIGHT;
        endcase
        return w;
    endfunction

    // Keyword text is stored with the first character in the lowest byte.
    function automatic khm_slot_t slot_entry(input logic [SLOT_W-1:0] idx);
        khm_slot_t s;
        case (idx)
            5'd2:    s = '{4'd2, KW_IN,       64'h0000_0000_0000_6E69};
            5'd3:    s = '{4'd3, KW_NIL,      64'h0000_0000_006C_696E};
            5'd5:    s = '{4'd5, KW_LOCAL,    64'h0000_006C_6163_6F6C};
            5'd6:    s = '{4'd6, KW_RETURN,   64'h0000_6E72_7574_6572};
            5'd7:    s = '{4'd2, KW_IF,       64'h0000_0000_0000_6669};
            5'd8:    s = '{4'd3, KW_FOR,      64'h0000_0000_0072_6F66};
            5'd10:   s = '{4'd5, KW_WHILE,    64'h0000_0065_6C69_6877};
            5'd12:   s = '{4'd2, KW_OR,       64'h0000_0000_0000_726F};
            5'd13:   s = '{4'd8, KW_FUNCTION, 64'h6E6F_6974_636E_7566};
            5'd14:   s = '{4'd4, KW_ELSE,     64'h0000_0000_6573_6C65};
            5'd15:   s = '{4'd5, KW_FALSE,    64'h0000_0065_736C_6166};
            5'd16:   s = '{4'd6, KW_ELSEIF,   64'h0000_6669_6573_6C65};
            5'd18:   s = '{4'd3, KW_NOT,      64'h0000_0000_0074_6F6E};
            5'd19:   s = '{4'd4, KW_THEN,     64'h0000_0000_6E65_6874};
            5'd20:   s = '{4'd5, KW_UNTIL,    64'h0000_006C_6974_6E75};
            5'd21:   s = '{4'd6, KW_REPEAT,   64'h0000_7461_6570_6572};
            5'd23:   s = '{4'd3, KW_END,      64'h0000_0000_0064_6E65};
            5'd24:   s = '{4'd4, KW_TRUE,     64'h0000_0000_6575_7274};
            5'd25:   s = '{4'd5, KW_BREAK,    64'h0000_006B_6165_7262};
            5'd27:   s = '{4'd2, KW_DO,       64'h0000_0000_0000_6F64};
            5'd28:   s = '{4'd3, KW_AND,      64'h0000_0000_0064_6E61};
            5'd29:   s = '{4'd4, KW_GOTO,     64'h0000_0000_6F74_6F67};
            default: s = '{4'd0, NO_KEYWORD,  64'h0};
        endcase
        return s;
    endfunction

endpackage

>>> hdl/keyword_perfect_hash_matcher.sv
// ----------------------------------------------------------------------------
// Keyword perfect hash matcher
// Classifies one candidate word per cycle, unless the output stalls, as a keyword code or as no keyword.
// ----------------------------------------------------------------------------
// The block accepts one item in every cycle while the output is not stalled
// and returns exactly one result for each, in order. The item is captured in
// an input register, the hash, slot lookup and byte compare run in one short
// combinational pass, and the answer is held in a result register; a stall on
// the output holds both stages in place.
module keyword_perfect_hash_matcher #(
    parameter int unsigned MAX_WORD_CHARS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  khm_pkg::khm_in_t   s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output khm_pkg::khm_out_t  m_payload
);

`include "keyword_perfect_hash_matcher_assert.svh"

    logic               in_valid_reg;
    logic               in_valid_next;
    khm_pkg::khm_in_t   in_item_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    khm_pkg::khm_out_t  out_item_reg;
    khm_pkg::khm_out_t  classified;
    logic               out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_free;

    khm_classify #(
        .MAX_WORD_CHARS(MAX_WORD_CHARS)
    ) u_classify (
        .item   (in_item_reg),
        .result (classified)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = in_valid_reg;
        end
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_payload;
        end
        if (out_free && in_valid_reg) begin
            out_item_reg <= classified;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_item_reg;

    `KHM_ASSERT_SAME(a_flag_matches_code, aclk, aresetn, m_valid,
        m_payload.is_keyword == (m_payload.token_code != khm_pkg::NO_KEYWORD))
    `KHM_ASSERT_SAME(a_code_in_range, aclk, aresetn, m_valid,
        m_payload.token_code <= khm_pkg::NO_KEYWORD)
    `KHM_ASSERT_NEXT(a_item_advances, aclk, aresetn, in_valid_reg && out_free, m_valid)
    `KHM_ASSERT_NEXT(a_item_captured, aclk, aresetn, s_valid && s_ready, in_valid_reg)

endmodule

>>> hdl/khm_classify.sv
// ----------------------------------------------------------------------------
// Keyword classifier
// Forms the perfect hash of one word, reads its slot and compares the bytes.
// ----------------------------------------------------------------------------
module khm_classify #(
    parameter int unsigned MAX_WORD_CHARS = 8
) (
    input  khm_pkg::khm_in_t  item,
    output khm_pkg::khm_out_t result
);

    logic [2:0]                       len_m1;
    logic [7:0]                       first_byte;
    logic [7:0]                       last_byte;
    logic [khm_pkg::HASH_W-1:0]       hash;
    logic                             len_ok;
    khm_pkg::khm_slot_t               slot;
    logic [khm_pkg::WORD_BYTES_W-1:0] byte_mask;
    logic                             match;

    assign len_m1     = item.word_length[2:0] - 3'd1;
    assign first_byte = item.word_bytes[7:0];
    assign last_byte  = item.word_bytes[{len_m1, 3'b000} +: 8];

    assign len_ok = (item.word_length >= khm_pkg::MIN_CHARS) &&
                    (item.word_length <= 8'(MAX_WORD_CHARS));

    assign hash = 7'(item.word_length[3:0]) + khm_pkg::byte_weight(last_byte)
                  + khm_pkg::byte_weight(first_byte);

    assign slot = khm_pkg::slot_entry(hash[khm_pkg::SLOT_W-1:0]);

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            byte_mask[i*8 +: 8] = (item.word_length > 8'(i)) ? 8'hFF : 8'h00;
        end
    end

    assign match = len_ok && (hash <= khm_pkg::HASH_LIMIT) &&
                   (item.word_length == 8'(slot.length)) &&
                   (((item.word_bytes ^ slot.text) & byte_mask) == '0);

    assign result.token_code = match ? slot.code : khm_pkg::NO_KEYWORD;
    assign result.is_keyword = match;

endmodule
